>>> sv/lkbs_pkg.sv
// ----------------------------------------------------------------------------
// lkbs_pkg: shared definitions for the link keepalive backoff supervisor
// Operation, status and ping timer codes, register indexes, reset values
// and the transaction payload types used across the block.
// ----------------------------------------------------------------------------
package lkbs_pkg;

  localparam int unsigned OpW      = 4;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned BackoffW = 16;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 32;

  // Event operation codes
  localparam logic [OpW-1:0] OP_OPEN          = 4'd0;
  localparam logic [OpW-1:0] OP_CONNECT_DONE  = 4'd1;
  localparam logic [OpW-1:0] OP_LOST          = 4'd2;
  localparam logic [OpW-1:0] OP_ERROR         = 4'd3;
  localparam logic [OpW-1:0] OP_DATA          = 4'd4;
  localparam logic [OpW-1:0] OP_PING_CHECK    = 4'd5;
  localparam logic [OpW-1:0] OP_RESTART_FIRE  = 4'd6;
  localparam logic [OpW-1:0] OP_ONLINE_CHANGE = 4'd7;
  localparam logic [OpW-1:0] OP_CLOSE         = 4'd8;
  localparam logic [OpW-1:0] OP_CONSUME_FAIL  = 4'd9;

  // Reported link status
  localparam logic [StatusW-1:0] STAT_DISCONNECTED = 2'd0;
  localparam logic [StatusW-1:0] STAT_CONNECTING   = 2'd1;
  localparam logic [StatusW-1:0] STAT_CONNECTED    = 2'd2;
  localparam logic [StatusW-1:0] STAT_CLOSED       = 2'd3;

  // Ping check timer commands
  localparam logic [CmdW-1:0] CMD_NONE  = 2'd0;
  localparam logic [CmdW-1:0] CMD_START = 2'd1;
  localparam logic [CmdW-1:0] CMD_STOP  = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MIN_BACKOFF = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_BACKOFF = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_PING_IDLE   = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_PING_FAIL   = 4'd3;

  // Register reset values
  localparam logic [BackoffW-1:0] MIN_BACKOFF_RST = 16'd250;
  localparam logic [BackoffW-1:0] MAX_BACKOFF_RST = 16'd59000;
  localparam logic [TimeW-1:0]    PING_IDLE_RST   = 32'd30000;
  localparam logic [TimeW-1:0]    PING_FAIL_RST   = 32'd60000;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [TimeW-1:0] now_ms;
    logic             success;
    logic             nonempty;
    logic             online_now;
  } event_t;

  typedef struct packed {
    logic [StatusW-1:0]  link_status;
    logic                status_changed;
    logic                send_ping;
    logic [CmdW-1:0]     ping_timer_cmd;
    logic                start_connect;
    logic                restart_scheduled;
    logic [BackoffW-1:0] restart_delay_ms;
  } result_t;

  typedef struct packed {
    logic [BackoffW-1:0] min_backoff_ms;
    logic [BackoffW-1:0] max_backoff_ms;
    logic [TimeW-1:0]    ping_idle_ms;
    logic [TimeW-1:0]    ping_fail_ms;
  } cfg_t;

endpackage

>>> sv/lkbs_event_if.sv
// ----------------------------------------------------------------------------
// lkbs_event_if: event channel
// Valid/ready channel carrying one timestamped link event per transaction.
// ----------------------------------------------------------------------------
interface lkbs_event_if;
  import lkbs_pkg::*;

  logic             valid;
  logic             ready;
  logic [OpW-1:0]   operation;
  logic [TimeW-1:0] now_ms;
  logic             success;
  logic             nonempty;
  logic             online_now;

  modport source (
    output valid, operation, now_ms, success, nonempty, online_now,
    input  ready
  );

  modport sink (
    input  valid, operation, now_ms, success, nonempty, online_now,
    output ready
  );
endinterface

>>> sv/lkbs_result_if.sv
// ----------------------------------------------------------------------------
// lkbs_result_if: result channel
// Valid/ready channel carrying the supervisor response to one event.
// ----------------------------------------------------------------------------
interface lkbs_result_if;
  import lkbs_pkg::*;

  logic                valid;
  logic                ready;
  logic [StatusW-1:0]  link_status;
  logic                status_changed;
  logic                send_ping;
  logic [CmdW-1:0]     ping_timer_cmd;
  logic                start_connect;
  logic                restart_scheduled;
  logic [BackoffW-1:0] restart_delay_ms;

  modport source (
    output valid, link_status, status_changed, send_ping, ping_timer_cmd,
           start_connect, restart_scheduled, restart_delay_ms,
    input  ready
  );

  modport sink (
    input  valid, link_status, status_changed, send_ping, ping_timer_cmd,
           start_connect, restart_scheduled, restart_delay_ms,
    output ready
  );
endinterface

>>> sv/lkbs_cfg_if.sv
// ----------------------------------------------------------------------------
// lkbs_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface lkbs_cfg_if;
  import lkbs_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

>>> sv/lkbs_cfg_regs.sv
// ----------------------------------------------------------------------------
// lkbs_cfg_regs: configuration register file
// Holds the backoff limits and ping thresholds; takes a write every cycle.
// ----------------------------------------------------------------------------
module lkbs_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  lkbs_cfg_if.sink      cfg_i,
  output lkbs_pkg::cfg_t cfg_o
);
  import lkbs_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr;

  // Always ready for a write transaction
  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (cfg_i.index)
        CFG_MIN_BACKOFF: cfg_d.min_backoff_ms = cfg_i.data[BackoffW-1:0];
        CFG_MAX_BACKOFF: cfg_d.max_backoff_ms = cfg_i.data[BackoffW-1:0];
        CFG_PING_IDLE:   cfg_d.ping_idle_ms   = cfg_i.data[TimeW-1:0];
        CFG_PING_FAIL:   cfg_d.ping_fail_ms   = cfg_i.data[TimeW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_backoff_ms <= MIN_BACKOFF_RST;
      cfg_q.max_backoff_ms <= MAX_BACKOFF_RST;
      cfg_q.ping_idle_ms   <= PING_IDLE_RST;
      cfg_q.ping_fail_ms   <= PING_FAIL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/lkbs_core.sv
// ----------------------------------------------------------------------------
// lkbs_core: link supervisor state and event decode
// Holds the link state, timestamps, backoff and flags, and works out the
// response to one registered event combinationally.
// ----------------------------------------------------------------------------
module lkbs_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  lkbs_pkg::event_t  evt_i,
  input  lkbs_pkg::cfg_t    cfg_i,
  output lkbs_pkg::result_t res_o
);
  import lkbs_pkg::*;

  typedef enum logic [2:0] {
    ST_NONE,
    ST_CONNECTING,
    ST_READY,
    ST_FAILED,
    ST_CLOSED
  } link_state_e;

  link_state_e         state_q, state_d;
  logic [TimeW-1:0]    last_rx_q, last_rx_d;
  logic [TimeW-1:0]    last_rst_q, last_rst_d;
  logic [BackoffW-1:0] backoff_q, backoff_d;
  logic                pending_q, pending_d;
  logic                online_q, online_d;

  logic [TimeW-1:0]    since, idle;
  logic [BackoffW-1:0] arm_base, arm_wait, dbl_sat;
  logic [BackoffW:0]   dbl;
  logic                arm_short, do_arm, arm_ok, force_change;
  result_t             res;

  // Restart arithmetic; an online change rearms from the minimum backoff
  assign arm_base  = (evt_i.operation == OP_ONLINE_CHANGE) ? cfg_i.min_backoff_ms
                                                           : backoff_q;
  assign since     = evt_i.now_ms - last_rst_q;
  assign arm_short = since < {{(TimeW-BackoffW){1'b0}}, arm_base};
  assign arm_wait  = arm_base - since[BackoffW-1:0];
  assign dbl       = {arm_base, 1'b0};
  assign dbl_sat   = (dbl > {1'b0, cfg_i.max_backoff_ms}) ? cfg_i.max_backoff_ms
                                                          : dbl[BackoffW-1:0];
  assign idle      = evt_i.now_ms - last_rx_q;

  // Decode the event
  always_comb begin
    state_d      = state_q;
    last_rx_d    = last_rx_q;
    last_rst_d   = last_rst_q;
    backoff_d    = backoff_q;
    pending_d    = pending_q;
    online_d     = online_q;
    do_arm       = 1'b0;
    force_change = 1'b0;
    res          = '0;

    case (evt_i.operation)
      OP_OPEN: begin
        if (state_q != ST_CLOSED) begin
          state_d           = ST_CONNECTING;
          res.start_connect = 1'b1;
        end
      end
      OP_CONNECT_DONE: begin
        if (!evt_i.success) begin
          state_d = ST_FAILED;
          do_arm  = 1'b1;
        end else begin
          state_d            = ST_READY;
          res.send_ping      = 1'b1;
          res.ping_timer_cmd = CMD_START;
          backoff_d          = cfg_i.min_backoff_ms;
          last_rx_d          = evt_i.now_ms;
        end
      end
      OP_LOST: begin
        do_arm = 1'b1;
      end
      OP_ERROR: begin
        state_d = ST_FAILED;
        do_arm  = 1'b1;
      end
      OP_DATA: begin
        if (state_q != ST_CLOSED && evt_i.nonempty) begin
          last_rx_d          = evt_i.now_ms;
          res.ping_timer_cmd = CMD_START;
        end
      end
      OP_PING_CHECK: begin
        if (idle > cfg_i.ping_fail_ms) begin
          state_d = ST_FAILED;
          do_arm  = 1'b1;
        end else begin
          res.send_ping      = (idle > cfg_i.ping_idle_ms) && (state_q == ST_READY);
          res.ping_timer_cmd = CMD_START;
        end
      end
      OP_RESTART_FIRE: begin
        // Passes through failed into connecting, so always a change
        pending_d          = 1'b0;
        last_rst_d         = evt_i.now_ms;
        res.ping_timer_cmd = CMD_STOP;
        state_d            = ST_CONNECTING;
        force_change       = 1'b1;
        res.start_connect  = 1'b1;
      end
      OP_ONLINE_CHANGE: begin
        if (online_q != evt_i.online_now) begin
          online_d = evt_i.online_now;
          if (state_q != ST_CLOSED && evt_i.online_now) begin
            state_d   = ST_FAILED;
            pending_d = 1'b0;
            backoff_d = cfg_i.min_backoff_ms;
            do_arm    = 1'b1;
          end
        end
      end
      OP_CLOSE: begin
        if (state_q != ST_CLOSED) begin
          state_d            = ST_CLOSED;
          res.ping_timer_cmd = CMD_STOP;
        end
      end
      OP_CONSUME_FAIL: begin
        if (state_q != ST_CLOSED) begin
          state_d = ST_FAILED;
          do_arm  = 1'b1;
        end
      end
      default: begin
        state_d = state_q;
      end
    endcase

    // Arm the restart timer unless closed, connecting, offline or pending
    arm_ok = do_arm && state_d != ST_CLOSED && state_d != ST_CONNECTING &&
             online_d && !pending_d;
    if (arm_ok) begin
      pending_d             = 1'b1;
      res.restart_scheduled = 1'b1;
      if (arm_short) begin
        res.restart_delay_ms = arm_wait;
        backoff_d            = dbl_sat;
      end
    end

    res.status_changed = force_change || (state_d != state_q);
    case (state_d)
      ST_CONNECTING: res.link_status = STAT_CONNECTING;
      ST_READY:      res.link_status = STAT_CONNECTED;
      ST_CLOSED:     res.link_status = STAT_CLOSED;
      default:       res.link_status = STAT_DISCONNECTED;
    endcase
  end

  // Commit the state only when the event moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_NONE;
      last_rx_q  <= '0;
      last_rst_q <= '0;
      backoff_q  <= MIN_BACKOFF_RST;
      pending_q  <= 1'b0;
      online_q   <= 1'b0;
    end else if (step_i) begin
      state_q    <= state_d;
      last_rx_q  <= last_rx_d;
      last_rst_q <= last_rst_d;
      backoff_q  <= backoff_d;
      pending_q  <= pending_d;
      online_q   <= online_d;
    end
  end

  assign res_o = res;

  a_restart_fire_connects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && evt_i.operation == OP_RESTART_FIRE |=> state_q == ST_CONNECTING && !pending_q)
    else $error("restart fire did not leave a connecting link without a pending restart");

  a_delay_needs_sched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.restart_delay_ms != '0 |-> res.restart_scheduled)
    else $error("restart delay reported without a scheduled restart");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(state_q) && $stable(pending_q) && $stable(backoff_q))
    else $error("supervisor state moved without an event");

endmodule

>>> sv/link_keepalive_backoff_supervisor_unit.sv
// ----------------------------------------------------------------------------
// link_keepalive_backoff_supervisor_unit: link supervisor with keepalive
// Takes one timestamped link event per transaction on evt_i and answers one
// result on res_o through the event and result registers, with the link
// status, ping and connect requests, the ping check timer command and any
// armed restart delay. A new event is taken every cycle unless a stalled
// result holds it back: the event register feeds combinational decode against
// the held link state, which is written together with the result register,
// so the sustained rate is one event per cycle while res_o is drained. A
// stalled result holds in the result register while one further event waits
// in the event register. Configuration writes on cfg_i are taken every cycle
// and apply to events that follow; write them while no event is in flight.
// ----------------------------------------------------------------------------
module link_keepalive_backoff_supervisor_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  lkbs_event_if.sink   evt_i,
  lkbs_cfg_if.sink     cfg_i,
  lkbs_result_if.source res_o
);
  import lkbs_pkg::*;

  event_t  evt_q, evt_d;
  logic    evt_valid_q, evt_valid_d;
  result_t res_q, res_d;
  logic    res_valid_q, res_valid_d;
  result_t core_res;
  cfg_t    cfg;
  logic    advance, step;

  lkbs_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  lkbs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .evt_i  (evt_q),
    .cfg_i  (cfg),
    .res_o  (core_res)
  );

  // Advance whenever the result register is free or being drained
  assign advance     = !res_valid_q || res_o.ready;
  assign step        = evt_valid_q && advance;
  assign evt_i.ready = !evt_valid_q || advance;

  // Capture the incoming transaction
  always_comb begin
    evt_d       = evt_q;
    evt_valid_d = evt_valid_q;
    if (evt_i.ready) begin
      evt_valid_d = evt_i.valid;
      if (evt_i.valid) begin
        evt_d.operation  = evt_i.operation;
        evt_d.now_ms     = evt_i.now_ms;
        evt_d.success    = evt_i.success;
        evt_d.nonempty   = evt_i.nonempty;
        evt_d.online_now = evt_i.online_now;
      end
    end
  end

  // Load or drop the result
  always_comb begin
    res_d       = res_q;
    res_valid_d = res_valid_q;
    if (step) begin
      res_d       = core_res;
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      evt_valid_q <= evt_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    evt_q <= evt_d;
    res_q <= res_d;
  end

  assign res_o.valid             = res_valid_q;
  assign res_o.link_status       = res_q.link_status;
  assign res_o.status_changed    = res_q.status_changed;
  assign res_o.send_ping         = res_q.send_ping;
  assign res_o.ping_timer_cmd    = res_q.ping_timer_cmd;
  assign res_o.start_connect     = res_q.start_connect;
  assign res_o.restart_scheduled = res_q.restart_scheduled;
  assign res_o.restart_delay_ms  = res_q.restart_delay_ms;

endmodule
